// ----- design/median_filter_3x3_core_assert.svh -----
// Assertion macros shared by the median filter checker.
`ifndef MEDIAN_FILTER_3X3_CORE_ASSERT_SVH
`define MEDIAN_FILTER_3X3_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MF3_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mf3 check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MF3_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mf3 check failed: next-cycle implication");

`endif

// ----- design/mf3_pkg.sv -----
// Shared constants, types and the median network for the 3x3 median filter.
`timescale 1ns / 1ps

package mf3_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_CHANNELS = 4;

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int CH_W        = 2;
    localparam int IDX_W       = COL_W + CH_W;
    localparam int STORE_DEPTH = (1 << COL_W) * MAX_CHANNELS;

    localparam int SAMPLE_W   = 8;
    localparam int WIDTH_CW   = 12;
    localparam int HEIGHT_CW  = 16;
    localparam int NCH_CW     = 3;
    localparam int EFF_W_W    = COL_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [WIDTH_CW-1:0]  RST_IMAGE_WIDTH   = 12'd640;
    localparam logic [HEIGHT_CW-1:0] RST_IMAGE_HEIGHT  = 16'd480;
    localparam logic [NCH_CW-1:0]    RST_CHANNEL_COUNT = 3'd3;

    typedef struct packed {
        logic [WIDTH_CW-1:0]  width;
        logic [HEIGHT_CW-1:0] height;
        logic [NCH_CW-1:0]    nch;
    } cfg_t;

    // Position of one sample and what its transaction must do.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CH_W-1:0]  ch;
        logic             emit;
        logic             full;
        logic             last;
    } pos_t;

    typedef logic [8:0][SAMPLE_W-1:0] nine_t;

    // {min, max}
    function automatic logic [2*SAMPLE_W-1:0] sort2(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b
    );
        return (a > b) ? {b, a} : {a, b};
    endfunction

    // 19 compare-exchange median-of-nine network.
    function automatic logic [SAMPLE_W-1:0] med9(input nine_t v);
        nine_t p;
        p = v;
        {p[1], p[2]} = sort2(p[1], p[2]);
        {p[4], p[5]} = sort2(p[4], p[5]);
        {p[7], p[8]} = sort2(p[7], p[8]);
        {p[0], p[1]} = sort2(p[0], p[1]);
        {p[3], p[4]} = sort2(p[3], p[4]);
        {p[6], p[7]} = sort2(p[6], p[7]);
        {p[1], p[2]} = sort2(p[1], p[2]);
        {p[4], p[5]} = sort2(p[4], p[5]);
        {p[7], p[8]} = sort2(p[7], p[8]);
        {p[0], p[3]} = sort2(p[0], p[3]);
        {p[5], p[8]} = sort2(p[5], p[8]);
        {p[4], p[7]} = sort2(p[4], p[7]);
        {p[3], p[6]} = sort2(p[3], p[6]);
        {p[1], p[4]} = sort2(p[1], p[4]);
        {p[2], p[5]} = sort2(p[2], p[5]);
        {p[4], p[7]} = sort2(p[4], p[7]);
        {p[4], p[2]} = sort2(p[4], p[2]);
        {p[6], p[4]} = sort2(p[6], p[4]);
        {p[4], p[2]} = sort2(p[4], p[2]);
        return p[4];
    endfunction

endpackage

// ----- design/mf3_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/mf3_position.sv -----
// Raster position counters, register clamping and line store address.
`timescale 1ns / 1ps

module mf3_position (
    input  logic          clk,
    input  logic          rst_n,
    input  mf3_pkg::cfg_t cfg,
    input  logic          accept,
    input  logic          frame_start,
    output mf3_pkg::pos_t pos
);

    localparam int EW = mf3_pkg::EFF_W_W;
    localparam int HW = mf3_pkg::HEIGHT_CW;
    localparam int NW = mf3_pkg::NCH_CW;
    localparam int CW = mf3_pkg::COL_W;
    localparam int KW = mf3_pkg::CH_W;

    logic [CW-1:0] col_reg, col_next, cur_col;
    logic [HW-1:0] row_reg, row_next, cur_row;
    logic [KW-1:0] ch_reg, ch_next, cur_ch;

    logic [EW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [NW-1:0] eff_n;
    logic [NW-1:0] ch_inc;
    logic [EW-1:0] col_inc;
    logic [HW:0]   row_inc;

    // Out-of-range registers act as the nearest legal value.
    always_comb
    begin
        if (cfg.width == '0)
            eff_w = EW'(1);
        else if (32'(cfg.width) > mf3_pkg::MAX_WIDTH)
            eff_w = EW'(mf3_pkg::MAX_WIDTH);
        else
            eff_w = EW'(cfg.width);

        eff_h = (cfg.height == '0) ? HW'(1) : cfg.height;

        if (cfg.nch == '0)
            eff_n = NW'(1);
        else if (32'(cfg.nch) > mf3_pkg::MAX_CHANNELS)
            eff_n = NW'(mf3_pkg::MAX_CHANNELS);
        else
            eff_n = cfg.nch;
    end

    assign cur_col = frame_start ? '0 : col_reg;
    assign cur_row = frame_start ? '0 : row_reg;
    assign cur_ch  = frame_start ? '0 : ch_reg;

    assign ch_inc  = NW'(cur_ch) + NW'(1);
    assign col_inc = EW'(cur_col) + EW'(1);
    assign row_inc = (HW + 1)'(cur_row) + (HW + 1)'(1);

    always_comb
    begin
        ch_next  = cur_ch;
        col_next = cur_col;
        row_next = cur_row;
        if (ch_inc >= eff_n)
        begin
            ch_next = '0;
            if (col_inc >= eff_w)
            begin
                col_next = '0;
                row_next = (row_inc >= (HW + 1)'(eff_h)) ? '0 : row_inc[HW-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
        else
        begin
            ch_next = ch_inc[KW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            ch_reg  <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            ch_reg  <= ch_next;
        end
    end

    assign pos.idx  = {cur_col, cur_ch};
    assign pos.ch   = cur_ch;
    assign pos.emit = (cur_row != '0) && (cur_col != '0);
    assign pos.full = (cur_row >= HW'(2)) && (cur_col >= CW'(2));
    assign pos.last = (cur_row == eff_h - HW'(1))
                    && (EW'(cur_col) == eff_w - EW'(1))
                    && (NW'(cur_ch) == eff_n - NW'(1));

endmodule

// ----- design/mf3_window.sv -----
// Per-channel 3x3 window columns and the median network.
`timescale 1ns / 1ps

module mf3_window (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           update,
    input  mf3_pkg::pos_t                  pos,
    input  logic [mf3_pkg::SAMPLE_W-1:0]   top,
    input  logic [mf3_pkg::SAMPLE_W-1:0]   mid,
    input  logic [mf3_pkg::SAMPLE_W-1:0]   smp,
    output logic [mf3_pkg::SAMPLE_W-1:0]   median
);

    localparam int SW = mf3_pkg::SAMPLE_W;

    // older column (a) and newer column (b), rows top/mid/bottom
    logic [SW-1:0] col_a_reg [mf3_pkg::MAX_CHANNELS][3];
    logic [SW-1:0] col_b_reg [mf3_pkg::MAX_CHANNELS][3];

    mf3_pkg::nine_t v;

    always_comb
    begin
        v[0] = col_a_reg[pos.ch][0];
        v[1] = col_b_reg[pos.ch][0];
        v[2] = top;
        v[3] = col_a_reg[pos.ch][1];
        v[4] = col_b_reg[pos.ch][1];
        v[5] = mid;
        v[6] = col_a_reg[pos.ch][2];
        v[7] = col_b_reg[pos.ch][2];
        v[8] = smp;
    end

    // border positions give zero
    assign median = pos.full ? mf3_pkg::med9(v) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mf3_pkg::MAX_CHANNELS; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    col_a_reg[i][j] <= '0;
                    col_b_reg[i][j] <= '0;
                end
            end
        end
        else if (update)
        begin
            col_a_reg[pos.ch][0] <= col_b_reg[pos.ch][0];
            col_a_reg[pos.ch][1] <= col_b_reg[pos.ch][1];
            col_a_reg[pos.ch][2] <= col_b_reg[pos.ch][2];
            col_b_reg[pos.ch][0] <= top;
            col_b_reg[pos.ch][1] <= mid;
            col_b_reg[pos.ch][2] <= smp;
        end
    end

endmodule

// ----- design/median_filter_3x3_core.sv -----
// out_valid is registered: an accepted input passes the stage 1 and result registers.
// Throughput: one sample per cycle unless a held result stalls; each store read overlaps
//   the window update and store write of the sample before, with forwarding between them.
// Reset (rst_n low, async): counters, window columns and valid flags clear, registers
//   return to 640 x 480 x 3; the line stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module median_filter_3x3_core (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mf3_pkg::SAMPLE_W-1:0]      sample,
    input  logic                              frame_start,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mf3_pkg::SAMPLE_W-1:0]      filtered_sample,
    output logic                              frame_done
);

    localparam int SW = mf3_pkg::SAMPLE_W;

    // ------------------------------------------------------------------
    // Configuration registers. Users must write them only while the pipe is empty; not enforced.
    // ------------------------------------------------------------------
    mf3_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= mf3_pkg::RST_IMAGE_WIDTH;
            cfg_reg.height <= mf3_pkg::RST_IMAGE_HEIGHT;
            cfg_reg.nch    <= mf3_pkg::RST_CHANNEL_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mf3_pkg::REG_IMAGE_WIDTH:
                    cfg_reg.width <= cfg_data[mf3_pkg::WIDTH_CW-1:0];
                mf3_pkg::REG_IMAGE_HEIGHT:
                    cfg_reg.height <= cfg_data[mf3_pkg::HEIGHT_CW-1:0];
                mf3_pkg::REG_CHANNEL_COUNT:
                    cfg_reg.nch <= cfg_data[mf3_pkg::NCH_CW-1:0];
                default:
                    ; // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipe control. Everything moves together when the result register
    // is free or being drained; an input transaction is taken then.
    // ------------------------------------------------------------------
    logic advance;
    logic accept;
    logic out_valid_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && in_ready;

    // Stage 0: position and line store read address.
    mf3_pkg::pos_t in_pos;

    mf3_position u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (accept),
        .frame_start (frame_start),
        .pos         (in_pos)
    );

    // Stage 1: store data back, window, median.
    logic          s1_valid_reg;
    mf3_pkg::pos_t s1_pos_reg;
    logic [SW-1:0] s1_sample_reg;

    // Store bypass: the previous sample wrote this very entry at the edge where this one read
    // it (when a row holds a single sample, or frame_start restarts at the entry just written).
    logic          fwd_hit_reg;
    logic [SW-1:0] fwd_upper_reg;
    logic [SW-1:0] fwd_middle_reg;

    logic [SW-1:0] upper_q;
    logic [SW-1:0] middle_q;
    logic [SW-1:0] top_val;
    logic [SW-1:0] mid_val;
    logic          s1_move;
    logic [SW-1:0] median;

    assign top_val = fwd_hit_reg ? fwd_upper_reg  : upper_q;
    assign mid_val = fwd_hit_reg ? fwd_middle_reg : middle_q;
    assign s1_move = s1_valid_reg && advance;

    mf3_ram #(
        .WIDTH (SW),
        .DEPTH (mf3_pkg::STORE_DEPTH)
    ) u_line_store_upper (
        .clk     (clk),
        .wr_en   (s1_move),
        .wr_addr (s1_pos_reg.idx),
        .wr_data (mid_val),
        .rd_en   (accept),
        .rd_addr (in_pos.idx),
        .rd_data (upper_q)
    );

    mf3_ram #(
        .WIDTH (SW),
        .DEPTH (mf3_pkg::STORE_DEPTH)
    ) u_line_store_middle (
        .clk     (clk),
        .wr_en   (s1_move),
        .wr_addr (s1_pos_reg.idx),
        .wr_data (s1_sample_reg),
        .rd_en   (accept),
        .rd_addr (in_pos.idx),
        .rd_data (middle_q)
    );

    mf3_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (s1_move),
        .pos    (s1_pos_reg),
        .top    (top_val),
        .mid    (mid_val),
        .smp    (s1_sample_reg),
        .median (median)
    );

    // ------------------------------------------------------------------
    // Result register. Samples in the first row or column leave no result.
    // ------------------------------------------------------------------
    logic          out_valid_next;
    logic [SW-1:0] out_sample_reg;
    logic          out_done_reg;

    assign out_valid_next = s1_valid_reg && s1_pos_reg.emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg  <= accept;
                out_valid_reg <= out_valid_next;
            end
            if (accept)
            begin
                fwd_hit_reg <= s1_valid_reg && (s1_pos_reg.idx == in_pos.idx);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg     <= in_pos;
            s1_sample_reg  <= sample;
            fwd_upper_reg  <= mid_val;
            fwd_middle_reg <= s1_sample_reg;
        end
        if (advance)
        begin
            out_sample_reg <= median;
            out_done_reg   <= s1_pos_reg.last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_sample = out_sample_reg;
    assign frame_done      = out_done_reg;

endmodule

// ----- design/mf3_checker.sv -----
// Port-level checker for the median filter core, bound to the top level.
`timescale 1ns / 1ps
`include "median_filter_3x3_core_assert.svh"

module mf3_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         frame_start,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [mf3_pkg::SAMPLE_W-1:0] filtered_sample,
    input logic                         frame_done
);

    // held result does not change while stalled
    `MF3_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(filtered_sample) && $stable(frame_done))

    // input side is open whenever the result register is empty
    `MF3_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)

    // a stalled result blocks new input
    `MF3_ASSERT_IMP(a_stall_blocks_input, out_valid && !out_ready, !in_ready)

    // the first sample of a frame sits on a border and yields no result
    `MF3_ASSERT_NXT(a_frame_start_silent, (in_valid && in_ready && frame_start) ##1 (!out_valid || out_ready), !out_valid)

endmodule

bind median_filter_3x3_core mf3_checker u_mf3_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .frame_start     (frame_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .filtered_sample (filtered_sample),
    .frame_done      (frame_done)
);

// ----- tb/sv/median_window_checker.sv -----
// Checker for the 3x3 median filter: watches all channels, predicts each result and compares.
`timescale 1ns / 1ps

module median_window_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [mf3_pkg::SAMPLE_W-1:0]      sample,
    input  logic                              frame_start,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [mf3_pkg::SAMPLE_W-1:0]      filtered_sample,
    input  logic                              frame_done,
    output int                                mismatch_count,
    output int                                pending_results,
    output int                                medians_checked,
    output int                                frames_finished
);
    import mf3_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                done;
    } median_result_t;

    logic [SAMPLE_W-1:0]  upper_line [0:STORE_DEPTH-1];
    logic [SAMPLE_W-1:0]  middle_line [0:STORE_DEPTH-1];
    // [channel][older/newer column][row top/mid/bottom]
    logic [SAMPLE_W-1:0]  window_px [0:MAX_CHANNELS-1][0:1][0:2];
    int unsigned          col_cnt;
    int unsigned          row_cnt;
    int unsigned          chan_idx;
    logic [WIDTH_CW-1:0]  width_reg;
    logic [HEIGHT_CW-1:0] height_reg;
    logic [NCH_CW-1:0]    nch_reg;
    median_result_t       expected_medians [$];

    // Zero acts as one, anything above the ceiling acts as the ceiling.
    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Median by rank: the value with at most four below it and at least five at or below.
    function automatic logic [SAMPLE_W-1:0] rank_median(input logic [8:0][SAMPLE_W-1:0] v);
        int below;
        int at_most;
        for (int i = 0; i < 9; i++)
        begin
            below = 0;
            at_most = 0;
            for (int j = 0; j < 9; j++)
            begin
                if (v[j] < v[i])
                    below++;
                if (v[j] <= v[i])
                    at_most++;
            end
            if (below <= 4 && at_most >= 5)
                return v[i];
        end
        return v[4];
    endfunction

    task automatic predict_window_step(input logic [SAMPLE_W-1:0] px, input logic fs);
        int unsigned         w;
        int unsigned         h;
        int unsigned         n;
        int unsigned         r;
        int unsigned         c;
        int unsigned         ch;
        int unsigned         idx;
        logic [SAMPLE_W-1:0] top_px;
        logic [SAMPLE_W-1:0] mid_px;
        logic [8:0][SAMPLE_W-1:0] nine;
        median_result_t      res;
        w = clamp_to(width_reg, MAX_WIDTH);
        h = clamp_to(height_reg, 65535);
        n = clamp_to(nch_reg, MAX_CHANNELS);
        if (fs)
        begin
            col_cnt = 0;
            row_cnt = 0;
            chan_idx = 0;
        end
        r = row_cnt;
        c = col_cnt;
        ch = chan_idx % MAX_CHANNELS;
        idx = (c % MAX_WIDTH) * MAX_CHANNELS + ch;
        top_px = upper_line[idx];
        mid_px = middle_line[idx];

        if (r >= 1 && c >= 1)
        begin
            res.value = '0;
            if (r >= 2 && c >= 2)
            begin
                nine[0] = window_px[ch][0][0];
                nine[1] = window_px[ch][1][0];
                nine[2] = top_px;
                nine[3] = window_px[ch][0][1];
                nine[4] = window_px[ch][1][1];
                nine[5] = mid_px;
                nine[6] = window_px[ch][0][2];
                nine[7] = window_px[ch][1][2];
                nine[8] = px;
                res.value = rank_median(nine);
            end
            res.done = (r == h - 1 && c == w - 1 && ch == n - 1);
            expected_medians.push_back(res);
        end

        for (int k = 0; k < 3; k++)
            window_px[ch][0][k] = window_px[ch][1][k];
        window_px[ch][1][0] = top_px;
        window_px[ch][1][1] = mid_px;
        window_px[ch][1][2] = px;
        upper_line[idx] = mid_px;
        middle_line[idx] = px;

        ch++;
        if (ch >= n)
        begin
            ch = 0;
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
                if (r >= h)
                    r = 0;
            end
        end
        chan_idx = ch;
        col_cnt = c;
        row_cnt = r;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                upper_line[i] = '0;
                middle_line[i] = '0;
            end
            for (int i = 0; i < MAX_CHANNELS; i++)
                for (int j = 0; j < 2; j++)
                    for (int k = 0; k < 3; k++)
                        window_px[i][j][k] = '0;
            col_cnt = 0;
            row_cnt = 0;
            chan_idx = 0;
            width_reg = RST_IMAGE_WIDTH;
            height_reg = RST_IMAGE_HEIGHT;
            nch_reg = RST_CHANNEL_COUNT;
            expected_medians.delete();
            mismatch_count = 0;
            medians_checked = 0;
            frames_finished = 0;
        end
        else
        begin
            // A result leaves only after its input is registered, so check results first.
            if (out_valid && out_ready)
            begin
                if (expected_medians.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: result with nothing pending: sample %0d done %0b",
                                 $time, filtered_sample, frame_done);
                    mismatch_count++;
                end
                else
                begin
                    median_result_t want;
                    want = expected_medians.pop_front();
                    medians_checked++;
                    if (filtered_sample !== want.value || frame_done !== want.done)
                    begin
                        if (mismatch_count < 10)
                            $display("%0t: mismatch: expected sample %0d done %0b, got %0d %0b",
                                     $time, want.value, want.done, filtered_sample, frame_done);
                        mismatch_count++;
                    end
                    else if (want.done)
                        frames_finished++;
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:   width_reg = cfg_data[WIDTH_CW-1:0];
                    REG_IMAGE_HEIGHT:  height_reg = cfg_data[HEIGHT_CW-1:0];
                    REG_CHANNEL_COUNT: nch_reg = cfg_data[NCH_CW-1:0];
                    default:           ;
                endcase
            end

            if (in_valid && in_ready)
                predict_window_step(sample, frame_start);
        end
        pending_results = expected_medians.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the median filter testbench: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps

module testbench;
    import mf3_pkg::*;

    // Index 3 maps to no register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1250;
    localparam int DRAIN_CYCLES = 8;

    // How sample values are drawn for one frame.
    typedef enum int {SPREAD_FULL, SPREAD_TIES, SPREAD_RAILS} spread_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [SAMPLE_W-1:0]   sample = '0;
    logic                  frame_start = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [SAMPLE_W-1:0]   filtered_sample;
    logic                  frame_done;

    int mismatch_count;
    int pending_results;
    int medians_checked;
    int frames_finished;

    // Idle odds in percent per cycle, changed as the run moves through its stretches.
    int send_idle_pct = 18;
    int recv_idle_pct = 52;
    int items_sent = 0;
    int settings_written = 0;

    always #2 clk = ~clk;

    median_filter_3x3_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample          (sample),
        .frame_start     (frame_start),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .filtered_sample (filtered_sample),
        .frame_done      (frame_done)
    );

    median_window_checker median_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample          (sample),
        .frame_start     (frame_start),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .filtered_sample (filtered_sample),
        .frame_done      (frame_done),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .medians_checked (medians_checked),
        .frames_finished (frames_finished)
    );

    // Receiver: back-pressure drawn fresh every cycle.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Zero acts as one and anything past the ceiling acts as the ceiling, as in the block.
    function automatic int unsigned effective_dim(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_value(input spread_t spread);
        case (spread)
            SPREAD_TIES:  return SAMPLE_W'($urandom_range(0, 3));
            SPREAD_RAILS: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:      return SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // One input transaction. Valid is left high after acceptance: the next call either
    // reuses it in the same step or drops it while idling, so it is never toggled twice
    // within one time step.
    task automatic push_sample(input logic [SAMPLE_W-1:0] px, input logic fs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= px;
        frame_start <= fs;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Let every expected result come out, then give the pipeline a few more cycles,
    // since items that cause no result may still be in flight.
    task automatic settle_pipeline();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after its last write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // All three registers, rotated from a random start, with junk above width and count.
    task automatic program_frame_format(input logic [WIDTH_CW-1:0] w,
                                        input logic [HEIGHT_CW-1:0] h,
                                        input logic [NCH_CW-1:0] n);
        logic [CFG_IDX_W-1:0]  order [0:2];
        logic [CFG_DATA_W-1:0] noise;
        int unsigned           start;
        order[0] = REG_IMAGE_WIDTH;
        order[1] = REG_IMAGE_HEIGHT;
        order[2] = REG_CHANNEL_COUNT;
        start = $urandom_range(0, 2);
        settle_pipeline();
        for (int k = 0; k < 3; k++)
        begin
            noise = CFG_DATA_W'($urandom);
            case (order[(start + k) % 3])
                REG_IMAGE_WIDTH:
                    write_register(REG_IMAGE_WIDTH, {noise[CFG_DATA_W-1:WIDTH_CW], w});
                REG_IMAGE_HEIGHT:
                    write_register(REG_IMAGE_HEIGHT, h);
                default:
                    write_register(REG_CHANNEL_COUNT, {noise[CFG_DATA_W-1:NCH_CW], n});
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            write_register(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    // A run of samples; frame_start on the first one as asked, and again at glitch_at
    // when that falls inside the run (a broken frame).
    task automatic send_frame(input int unsigned count, input logic fs_first,
                              input int unsigned glitch_at, input spread_t spread);
        for (int unsigned k = 0; k < count; k++)
            push_sample(pick_value(spread), (k == 0) ? fs_first : (k == glitch_at));
    endtask

    // Hard stop if the handshakes hang.
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [SAMPLE_W-1:0] corner_px [0:8];
        int unsigned         random_items;
        int unsigned         w_reg;
        int unsigned         h_reg;
        int unsigned         n_reg;
        int unsigned         frame_len;
        int unsigned         count;
        int unsigned         glitch;
        int unsigned         kind;
        int unsigned         frame_total;
        spread_t             spread;

        corner_px = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'h01, 8'hFE, 8'h0F};
        random_items = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- Directed part ---
        // 3x3 single-channel frame with rail and alternating-bit values: three border
        // zeros and one true median flagged as the frame end.
        program_frame_format(12'd3, 16'd3, 3'd1);
        for (int k = 0; k < 9; k++)
            push_sample(corner_px[k], k == 0);
        // Frame end without frame_start: counters wrap and a new frame begins.
        for (int k = 0; k < 5; k++)
            push_sample(corner_px[8 - k], 1'b0);

        // All registers zero: acts as a 1x1 frame with one channel, so nothing comes out.
        program_frame_format(12'd0, 16'd0, 3'd0);
        for (int k = 0; k < 3; k++)
            push_sample(pick_value(SPREAD_FULL), k == 0);

        // Width shrinks mid-frame while the column counter sits past the new bound.
        program_frame_format(12'd4, 16'd3, 3'd1);
        for (int k = 0; k < 7; k++)
            push_sample(pick_value(SPREAD_FULL), k == 0);
        settle_pipeline();
        write_register(REG_IMAGE_WIDTH, 16'd2);
        cfg_valid <= 1'b0;
        for (int k = 0; k < 4; k++)
            push_sample(pick_value(SPREAD_FULL), 1'b0);

        // --- Random part ---
        // Mostly whole frames with random content; some truncated, some broken by a
        // stray frame_start. Later frames of a setting may start without frame_start.
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 18;
                recv_idle_pct = 52;
            end
            else if (random_items < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 18;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case ($urandom_range(0, 9))
                0:       w_reg = $urandom_range(0, 2);
                1:       w_reg = $urandom_range(11, 32);
                default: w_reg = $urandom_range(3, 10);
            endcase
            case ($urandom_range(0, 9))
                0:       h_reg = $urandom_range(0, 2);
                1:       h_reg = $urandom_range(0, 1) ? 65535 : $urandom_range(7, 65534);
                default: h_reg = $urandom_range(3, 6);
            endcase
            n_reg = $urandom_range(0, 7);
            program_frame_format(WIDTH_CW'(w_reg), HEIGHT_CW'(h_reg), NCH_CW'(n_reg));

            frame_len = effective_dim(w_reg, MAX_WIDTH) * effective_dim(h_reg, 65535)
                        * effective_dim(n_reg, MAX_CHANNELS);
            frame_total = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frame_total; f++)
            begin
                count = (frame_len > 400) ? $urandom_range(100, 400) : frame_len;
                glitch = count;
                kind = $urandom_range(0, 9);
                if (kind == 8)
                    count = $urandom_range(1, count);
                else if (kind == 9 && count > 2)
                    glitch = $urandom_range(1, count - 1);
                spread = spread_t'($urandom_range(0, 2));
                // The first item after a register change always restarts the frame.
                send_frame(count, (f == 0) ? 1'b1 : 1'($urandom_range(0, 1)), glitch, spread);
                random_items += count;
            end
        end

        // Widest frame: width 4095 clamps to the full line store; a short stretch of
        // row 0 only.
        program_frame_format(12'hFFF, 16'd3, 3'd1);
        send_frame(40, 1'b1, 40, SPREAD_FULL);

        // Every register at its upper limit; a short stretch of row 0 only.
        program_frame_format(12'd2048, 16'd65535, 3'd4);
        send_frame(40, 1'b1, 40, SPREAD_FULL);

        settle_pipeline();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples over %0d register settings (tiny, wrapped, mid-frame, full-width).",
                 items_sent, settings_written);
        $display("Compared %0d filtered results, %0d of them frame ends.",
                 medians_checked, frames_finished);
        if (mismatch_count == 0 && pending_results == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
